FILE: rtl/core/four_level_page_table_walk_map_assert.svh
// Assertion macros for the RTL files of the page table walk block.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALK_MAP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALK_MAP_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define FLTW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FLTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fltw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fltw_pkg;

  localparam int unsigned POOL_PAGES = 16;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned ENTRIES    = 512;
  localparam int unsigned PAGE_W     = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned NFP_W      = $clog2(POOL_PAGES + 1);
  localparam int unsigned ADDR_W     = PAGE_W + IDX_W;
  localparam int unsigned DEPTH      = POOL_PAGES * ENTRIES;
  localparam int unsigned FRAME_W    = 40;
  localparam int unsigned ENTRY_W    = FRAME_W + 2;
  localparam int unsigned VA_W       = 48;
  localparam int unsigned PA_W       = 52;
  localparam int unsigned OFS_W      = 12;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_MAP   = 2'd1,
    STAT_MISALIGN  = 2'd2,
    STAT_POOL_FULL = 2'd3
  } status_e;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_MAP    = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_ALLOC,
    ST_LEAF,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            kind;
    logic [VA_W-1:0] virtual_address;
    logic [PA_W-1:0] physical_address;
    logic            writable;
  } in_t;

  typedef struct packed {
    logic [PA_W-1:0] frame_address;
    status_e         status;
  } out_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/fltw_store.sv
`timescale 1ns / 1ps
`default_nettype none

module fltw_store (
  input  wire logic                        clk_i,
  input  wire fltw_pkg::mem_req_t          req_i,
  output logic [fltw_pkg::ENTRY_W-1:0]     rdata_o
);

  logic [fltw_pkg::ENTRY_W-1:0] mem [fltw_pkg::DEPTH];
  logic [fltw_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/four_level_page_table_walk_map.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | fltw_pkg::in_t  (kind, addresses, writable)
// out     | output    | out_valid_o / out_stall_i | fltw_pkg::out_t (frame_address, status)
//
// One item at a time over a single-port table store with registered read data.
// Lookup: one read/check pair per level reached. Map: one read/check pair per level
// down to the first missing one, one write per missing level and one leaf write; a
// misaligned map goes straight to the result.
// After reset a clearing pass first zeroes all POOL_PAGES*512 entries.
// A stalled result holds in the output register; the next item runs behind it and waits.

`include "four_level_page_table_walk_map_assert.svh"

module four_level_page_table_walk_map (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire fltw_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output fltw_pkg::out_t      out_o
);

  fltw_pkg::state_e                state_q, state_d;
  fltw_pkg::in_t                   item_q, item_d;
  logic [1:0]                      lvl_q, lvl_d;
  logic [fltw_pkg::PAGE_W-1:0]     page_q, page_d;
  logic [fltw_pkg::NFP_W-1:0]      nfp_q, nfp_d;
  logic [fltw_pkg::ADDR_W-1:0]     clr_q, clr_d;
  fltw_pkg::out_t                  res_q, res_d;
  fltw_pkg::out_t                  out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  fltw_pkg::mem_req_t              mem_req;
  logic [fltw_pkg::ENTRY_W-1:0]    rdata;

  logic                            in_fire;
  logic                            misaligned;
  logic                            present;
  logic                            in_pool;
  logic                            pool_short;
  logic                            out_free;
  logic                            clr_last;
  logic [fltw_pkg::FRAME_W-1:0]    nxt;
  logic [fltw_pkg::IDX_W-1:0]      idx;
  logic [fltw_pkg::IDX_W-1:0]      leaf_idx;
  logic [1:0]                      need;
  logic [fltw_pkg::NFP_W:0]        need_sum;

  fltw_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Index for the current level, top level first.
  always_comb begin
    case (lvl_q)
      2'd0:    idx = item_q.virtual_address[47:39];
      2'd1:    idx = item_q.virtual_address[38:30];
      2'd2:    idx = item_q.virtual_address[29:21];
      default: idx = item_q.virtual_address[20:12];
    endcase
  end

  assign leaf_idx   = item_q.virtual_address[20:12];
  assign in_fire    = in_valid_i && !in_stall_o;
  assign misaligned = (in_i.virtual_address[fltw_pkg::OFS_W-1:0] != '0) ||
                      (in_i.physical_address[fltw_pkg::OFS_W-1:0] != '0);
  assign present    = rdata[0];
  assign nxt        = rdata[fltw_pkg::ENTRY_W-1:2];
  assign in_pool    = nxt < fltw_pkg::FRAME_W'(fltw_pkg::POOL_PAGES);
  assign need       = 2'd3 - lvl_q;
  assign need_sum   = {1'b0, nfp_q} + (fltw_pkg::NFP_W + 1)'(need);
  assign pool_short = need_sum > (fltw_pkg::NFP_W + 1)'(fltw_pkg::POOL_PAGES);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clr_last   = clr_q == fltw_pkg::ADDR_W'(fltw_pkg::DEPTH - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fltw_pkg::ST_CLEAR: begin
        if (clr_last) state_d = fltw_pkg::ST_IDLE;
      end
      fltw_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.kind == fltw_pkg::KIND_MAP && misaligned) begin
            state_d = fltw_pkg::ST_DONE;
          end else begin
            state_d = fltw_pkg::ST_READ;
          end
        end
      end
      fltw_pkg::ST_READ: state_d = fltw_pkg::ST_CHECK;
      fltw_pkg::ST_CHECK: begin
        if (item_q.kind == fltw_pkg::KIND_LOOKUP) begin
          if (lvl_q == 2'd3 || !present || !in_pool) begin
            state_d = fltw_pkg::ST_DONE;
          end else begin
            state_d = fltw_pkg::ST_READ;
          end
        end else if (present) begin
          if (!in_pool) begin
            state_d = fltw_pkg::ST_DONE;
          end else if (lvl_q == 2'd2) begin
            state_d = fltw_pkg::ST_LEAF;
          end else begin
            state_d = fltw_pkg::ST_READ;
          end
        end else if (pool_short) begin
          state_d = fltw_pkg::ST_DONE;
        end else begin
          state_d = fltw_pkg::ST_ALLOC;
        end
      end
      fltw_pkg::ST_ALLOC: begin
        if (lvl_q == 2'd2) state_d = fltw_pkg::ST_LEAF;
      end
      fltw_pkg::ST_LEAF: state_d = fltw_pkg::ST_DONE;
      fltw_pkg::ST_DONE: begin
        if (out_free) state_d = fltw_pkg::ST_IDLE;
      end
      default: state_d = fltw_pkg::ST_CLEAR;
    endcase
  end

  // Datapath, store requests and result.
  always_comb begin
    item_d        = item_q;
    lvl_d         = lvl_q;
    page_d        = page_q;
    nfp_d         = nfp_q;
    clr_d         = clr_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    mem_req.en    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = {page_q, idx};
    mem_req.wdata = '0;
    in_stall_o    = state_q != fltw_pkg::ST_IDLE;

    case (state_q)
      fltw_pkg::ST_CLEAR: begin
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = clr_q;
        clr_d        = clr_q + 1'b1;
      end
      fltw_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_d              = in_i;
          lvl_d               = 2'd0;
          page_d              = '0;
          res_d.frame_address = '0;
          res_d.status        = (in_i.kind == fltw_pkg::KIND_MAP && misaligned) ?
                                fltw_pkg::STAT_MISALIGN : fltw_pkg::STAT_OK;
        end
      end
      fltw_pkg::ST_READ: begin
        mem_req.en = 1'b1;
      end
      fltw_pkg::ST_CHECK: begin
        if (item_q.kind == fltw_pkg::KIND_LOOKUP) begin
          if (!present || (lvl_q != 2'd3 && !in_pool)) begin
            res_d.status = fltw_pkg::STAT_NOT_MAP;
          end else if (lvl_q == 2'd3) begin
            res_d.frame_address = {nxt, {fltw_pkg::OFS_W{1'b0}}};
          end else begin
            page_d = fltw_pkg::PAGE_W'(nxt);
            lvl_d  = lvl_q + 2'd1;
          end
        end else if (present) begin
          if (!in_pool) begin
            res_d.status = fltw_pkg::STAT_POOL_FULL;
          end else begin
            page_d = fltw_pkg::PAGE_W'(nxt);
            lvl_d  = lvl_q + 2'd1;
          end
        end else if (pool_short) begin
          res_d.status = fltw_pkg::STAT_POOL_FULL;
        end
      end
      fltw_pkg::ST_ALLOC: begin
        // Link a fresh page; the pages below it are still all zero.
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = {fltw_pkg::FRAME_W'(nfp_q), 1'b1, 1'b1};
        page_d        = fltw_pkg::PAGE_W'(nfp_q);
        nfp_d         = nfp_q + 1'b1;
        lvl_d         = lvl_q + 2'd1;
      end
      fltw_pkg::ST_LEAF: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = {page_q, leaf_idx};
        mem_req.wdata = {item_q.physical_address[fltw_pkg::PA_W-1:fltw_pkg::OFS_W],
                         item_q.writable, 1'b1};
      end
      fltw_pkg::ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fltw_pkg::ST_CLEAR;
      lvl_q       <= '0;
      page_q      <= '0;
      nfp_q       <= fltw_pkg::NFP_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      page_q      <= page_d;
      nfp_q       <= nfp_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `FLTW_ASSERT(a_write_states, clk_i, rst_ni, mem_req.we |-> (state_q == fltw_pkg::ST_CLEAR || state_q == fltw_pkg::ST_ALLOC || state_q == fltw_pkg::ST_LEAF), "table write outside clear, alloc or leaf")
  `FLTW_ASSERT(a_alloc_in_pool, clk_i, rst_ni, (state_q == fltw_pkg::ST_ALLOC) |-> (nfp_q < fltw_pkg::NFP_W'(fltw_pkg::POOL_PAGES)), "allocated page outside pool")
  `FLTW_ASSERT(a_check_after_read, clk_i, rst_ni, (state_q == fltw_pkg::ST_CHECK) |-> ($past(state_q) == fltw_pkg::ST_READ), "entry checked without a read the cycle before")
  `FLTW_ASSERT(a_nfp_moves_on_alloc, clk_i, rst_ni, !$stable(nfp_q) |-> ($past(state_q) == fltw_pkg::ST_ALLOC), "allocator moved outside alloc")

endmodule

`default_nettype wire
